[rtl/core/bdtw_pkg.sv]
package bdtw_pkg;

   localparam int MAX_LEN   = 256;
   localparam int IDX_W     = $clog2(MAX_LEN);
   localparam int CNT_W     = $clog2(MAX_LEN + 1);
   localparam int SAMPLE_W  = 16;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int COST_W    = 32;
   localparam int ROUGH_W   = 48;
   localparam int BAND_W    = 9;
   localparam int WIN_W     = CNT_W + 1;
   localparam int DIST_W    = 32;
   localparam int ACC_SQ_W  = 2 * COST_W;
   localparam int PROD_W    = ACC_SQ_W + ROUGH_W;
   localparam int MCNT_W    = $clog2(ROUGH_W);
   localparam int BIT_W     = $clog2(DIST_W);

   localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
   localparam logic [ROUGH_W-1:0] ROUGH_MAX = {ROUGH_W{1'b1}};
   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
   localparam logic [BAND_W-1:0]  BAND_RESET = BAND_W'(26);

   localparam logic REQ_REFERENCE = 1'b0;
   localparam logic REQ_QUERY     = 1'b1;

   // Everything one cell hands to its right-hand neighbor.
   typedef struct packed {
      logic                       tok_valid;
      logic [CNT_W-1:0]           tok_i;
      logic signed [SAMPLE_W-1:0] tok_r;
      logic [COST_W-1:0]          cost;
      logic                       ok;
      logic [COST_W-1:0]          prev;
      logic                       prev_ok;
      logic                       fin_valid;
      logic [COST_W-1:0]          fin_cost;
      logic                       fin_ok;
   } link_type;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                  input logic signed [SAMPLE_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      begin
         d = DIFF_W'(a) - DIFF_W'(b);
         abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      end
   endfunction

   function automatic logic [ROUGH_W-1:0] rough_add(input logic [ROUGH_W-1:0] r,
                                                    input logic signed [SAMPLE_W-1:0] a,
                                                    input logic signed [SAMPLE_W-1:0] b);
      logic [DIFF_W-1:0]  d;
      logic [SQ_W-1:0]    sq;
      logic [ROUGH_W:0]   sum;
      begin
         d   = abs_diff(a, b);
         sq  = SQ_W'(d) * SQ_W'(d);
         sum = (ROUGH_W + 1)'(r) + (ROUGH_W + 1)'(sq);
         rough_add = (sum >= (ROUGH_W + 1)'(ROUGH_MAX)) ? ROUGH_MAX : sum[ROUGH_W-1:0];
      end
   endfunction

endpackage

[rtl/core/bdtw_cell.sv]
module bdtw_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clr,
   input  logic [bdtw_pkg::IDX_W-1:0]           idx,
   input  logic [bdtw_pkg::CNT_W-1:0]           n,
   input  logic [bdtw_pkg::CNT_W-1:0]           m,
   input  logic [bdtw_pkg::WIN_W-1:0]           w,
   input  logic                                 q_we,
   input  logic [bdtw_pkg::IDX_W-1:0]           q_addr,
   input  logic signed [bdtw_pkg::SAMPLE_W-1:0] q_data,
   input  bdtw_pkg::link_type                   left,
   output bdtw_pkg::link_type                   right
);

   logic signed [bdtw_pkg::SAMPLE_W-1:0] q_ff;
   logic [bdtw_pkg::COST_W-1:0]          cost_ff, prev_ff, fin_cost_ff;
   logic                                 ok_ff, prev_ok_ff, fin_ok_ff, fin_valid_ff;
   logic                                 tok_valid_ff;
   logic [bdtw_pkg::CNT_W-1:0]           tok_i_ff;
   logic signed [bdtw_pkg::SAMPLE_W-1:0] tok_r_ff;

   logic [bdtw_pkg::CNT_W-1:0]  j, dist_ij;
   logic                        in_band, ok_in, is_final;
   logic [bdtw_pkg::COST_W-1:0] best, cost_in;
   logic [bdtw_pkg::COST_W:0]   sum;
   logic [bdtw_pkg::DIFF_W-1:0] c;

   always_comb begin
      j        = bdtw_pkg::CNT_W'(idx) + bdtw_pkg::CNT_W'(1);
      dist_ij  = (left.tok_i >= j) ? (left.tok_i - j) : (j - left.tok_i);
      in_band  = (j <= m) && (bdtw_pkg::WIN_W'(dist_ij) <= w);
      c        = bdtw_pkg::abs_diff(left.tok_r, q_ff);
      best     = '0;
      ok_in    = 1'b0;
      cost_in  = '0;
      sum      = '0;
      if (in_band) begin
         // Diagonal, up and left predecessors, smallest reachable one wins.
         if (left.prev_ok) begin
            best  = left.prev;
            ok_in = 1'b1;
         end
         if (ok_ff && (!ok_in || cost_ff < best)) begin
            best  = cost_ff;
            ok_in = 1'b1;
         end
         if (left.ok && (!ok_in || left.cost < best)) begin
            best  = left.cost;
            ok_in = 1'b1;
         end
         if (ok_in) begin
            sum     = {1'b0, best} + (bdtw_pkg::COST_W + 1)'(c);
            cost_in = (sum > (bdtw_pkg::COST_W + 1)'(bdtw_pkg::COST_MAX)) ?
                      bdtw_pkg::COST_MAX : sum[bdtw_pkg::COST_W-1:0];
         end
      end
      is_final = left.tok_valid && (left.tok_i == n) && (j == m);
   end

   always_ff @(posedge clock) begin
      if (q_we && q_addr == idx) begin
         q_ff <= q_data;
      end
      tok_i_ff <= left.tok_i;
      tok_r_ff <= left.tok_r;
      if (left.tok_valid) begin
         cost_ff <= cost_in;
         prev_ff <= cost_ff;
      end
      if (is_final) begin
         fin_cost_ff <= cost_in;
         fin_ok_ff   <= ok_in;
      end else begin
         fin_cost_ff <= left.fin_cost;
         fin_ok_ff   <= left.fin_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         tok_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         prev_ok_ff   <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= left.tok_valid;
         fin_valid_ff <= is_final || left.fin_valid;
         if (left.tok_valid) begin
            ok_ff      <= ok_in;
            prev_ok_ff <= ok_ff;
         end
      end
   end

   always_comb begin
      right.tok_valid = tok_valid_ff;
      right.tok_i     = tok_i_ff;
      right.tok_r     = tok_r_ff;
      right.cost      = cost_ff;
      right.ok        = ok_ff;
      right.prev      = prev_ff;
      right.prev_ok   = prev_ok_ff;
      right.fin_valid = fin_valid_ff;
      right.fin_cost  = fin_cost_ff;
      right.fin_ok    = fin_ok_ff;
   end

endmodule

[rtl/core/bdtw_corr.sv]
module bdtw_corr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bdtw_pkg::COST_W-1:0]         acc,
   input  logic [bdtw_pkg::ROUGH_W-1:0]        rmax,
   input  logic [bdtw_pkg::ROUGH_W-1:0]        rmin,
   output logic                                done,
   output logic [bdtw_pkg::DIST_W-1:0]         distance,
   output logic                                clipped
);

   typedef enum logic [5:0] {
      C_IDLE = 6'b000001,
      C_SQ   = 6'b000010,
      C_MUL  = 6'b000100,
      C_CHK  = 6'b001000,
      C_TRY  = 6'b010000,
      C_CMP  = 6'b100000
   } cstate_type;

   localparam int PW = bdtw_pkg::PROD_W;

   cstate_type                      state_ff, state_in;
   logic [bdtw_pkg::COST_W-1:0]     acc_ff;
   logic [bdtw_pkg::ROUGH_W-1:0]    rmax_ff, rmin_ff;
   logic [PW-1:0]                   mcand_ff, p_ff, q_ff, us_ff, rs_ff, t_ff;
   logic [bdtw_pkg::MCNT_W-1:0]     mcnt_ff;
   logic [bdtw_pkg::BIT_W-1:0]      bit_ff;
   logic [bdtw_pkg::DIST_W-1:0]     a_ff;
   logic                            done_ff, clip_ff, take;
   logic [PW-1:0]                   us_acc;

   assign done     = done_ff;
   assign distance = a_ff;
   assign clipped  = clip_ff;

   always_comb begin
      take   = (t_ff <= p_ff);
      us_acc = take ? (us_ff + (rs_ff << 1)) : us_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE: if (start) state_in = C_SQ;
         C_SQ:   state_in = C_MUL;
         C_MUL:  if (mcnt_ff == bdtw_pkg::MCNT_W'(bdtw_pkg::ROUGH_W - 1)) state_in = C_CHK;
         C_CHK:  state_in = (p_ff >= {rmin_ff, {bdtw_pkg::ACC_SQ_W{1'b0}}}) ? C_IDLE : C_TRY;
         C_TRY:  state_in = C_CMP;
         C_CMP:  state_in = (bit_ff == '0) ? C_IDLE : C_TRY;
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == C_CMP && bit_ff == '0) ||
                     (state_ff == C_CHK && state_in == C_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         C_IDLE: begin
            acc_ff  <= acc;
            rmax_ff <= rmax;
            rmin_ff <= rmin;
         end
         C_SQ: begin
            mcand_ff <= PW'(acc_ff * acc_ff);
            p_ff     <= '0;
            mcnt_ff  <= '0;
         end
         C_MUL: begin
            // Shift-and-add product of the squared cost and the larger roughness.
            if (rmax_ff[0]) p_ff <= p_ff + mcand_ff;
            mcand_ff <= mcand_ff << 1;
            rmax_ff  <= rmax_ff >> 1;
            mcnt_ff  <= mcnt_ff + bdtw_pkg::MCNT_W'(1);
         end
         C_CHK: begin
            clip_ff <= (p_ff >= {rmin_ff, {bdtw_pkg::ACC_SQ_W{1'b0}}});
            a_ff    <= (p_ff >= {rmin_ff, {bdtw_pkg::ACC_SQ_W{1'b0}}}) ?
                       bdtw_pkg::DIST_MAX : '0;
            q_ff    <= '0;
            us_ff   <= '0;
            rs_ff   <= PW'(rmin_ff) << (2 * (bdtw_pkg::DIST_W - 1));
            bit_ff  <= bdtw_pkg::BIT_W'(bdtw_pkg::DIST_W - 1);
         end
         C_TRY: begin
            // Trial square times rmin: q + (a*rmin << (b+1)) + (rmin << 2b).
            t_ff <= q_ff + us_ff + rs_ff;
         end
         C_CMP: begin
            if (take) q_ff <= t_ff;
            a_ff   <= {a_ff[bdtw_pkg::DIST_W-2:0], take};
            us_ff  <= us_acc >> 1;
            rs_ff  <= rs_ff >> 2;
            bit_ff <= bit_ff - bdtw_pkg::BIT_W'(1);
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/core/banded_dtw_distance_corrected_top.sv]
// Banded warping distance between a stored reference and a query, up to 256 signed
// Q8.8 samples each. Samples load at one word per cycle while the block is idle. After
// the query's last word the band is swept by a chain of 256 cells, one per query
// position, fed one reference sample per cycle; the final cost is taken from the chain
// end. A serial correction unit then runs a 48-step shift-add multiply and, unless the
// product clips, a 32-bit root search. After a query's last mark no word is taken
// until its result word has been accepted.
module banded_dtw_distance_corrected_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bdtw_pkg::BAND_W-1:0]          csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [bdtw_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bdtw_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                 rsp_saturated,
   output logic                                 rsp_invalid
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_FEED   = 7'b0000100,
      ST_WAIT   = 7'b0001000,
      ST_CSTART = 7'b0010000,
      ST_CORR   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   localparam int CW = bdtw_pkg::CNT_W;

   state_type state_ff, state_in;

   logic [bdtw_pkg::BAND_W-1:0]          band_ff;
   logic signed [bdtw_pkg::SAMPLE_W-1:0] ref_mem [bdtw_pkg::MAX_LEN];
   logic signed [bdtw_pkg::SAMPLE_W-1:0] rd_data_ff, last_ref_ff, last_q_ff;
   logic [CW-1:0]                        ref_cnt_ff, q_cnt_ff, feed_ff, rd_i_ff;
   logic [bdtw_pkg::ROUGH_W-1:0]         ref_rough_ff, q_rough_ff;
   logic                                 ref_closed_ff, rd_valid_ff;
   logic [bdtw_pkg::WIN_W-1:0]           w_ff;
   logic [bdtw_pkg::DIST_W-1:0]          dist_ff;
   logic                                 sat_ff, inv_ff, acc_sat_ff;
   logic [bdtw_pkg::COST_W-1:0]          acc_ff;

   logic                                 accept, ref_wr, q_wr, clr, invalid_now;
   logic [CW-1:0]                        ref_base_cnt;
   logic [bdtw_pkg::ROUGH_W-1:0]         ref_base_rough;
   logic [2*CW-1:0]                      band_prod;
   logic [CW-1:0]                        len_diff;
   logic [bdtw_pkg::WIN_W-1:0]           band_w;
   logic [bdtw_pkg::ROUGH_W-1:0]         rmax, rmin;
   logic                                 corr_done, corr_clip;
   logic [bdtw_pkg::DIST_W-1:0]          corr_dist;

   bdtw_pkg::link_type links [bdtw_pkg::MAX_LEN + 1];

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_distance  = dist_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_invalid   = inv_ff;

   always_comb begin
      accept         = req_valid && req_ready;
      ref_base_cnt   = ref_closed_ff ? '0 : ref_cnt_ff;
      ref_base_rough = ref_closed_ff ? '0 : ref_rough_ff;
      ref_wr         = accept && (req_type == bdtw_pkg::REQ_REFERENCE) &&
                       (ref_base_cnt < CW'(bdtw_pkg::MAX_LEN));
      q_wr           = accept && (req_type == bdtw_pkg::REQ_QUERY) &&
                       (q_cnt_ff < CW'(bdtw_pkg::MAX_LEN));
      clr            = (state_ff == ST_START);
      invalid_now    = (ref_cnt_ff == '0) || (q_cnt_ff == '0) ||
                       (ref_rough_ff == '0) || (q_rough_ff == '0);
      band_prod      = (2*CW)'(band_ff) * (2*CW)'(ref_cnt_ff);
      len_diff       = (ref_cnt_ff > q_cnt_ff) ? (ref_cnt_ff - q_cnt_ff) :
                                                 (q_cnt_ff - ref_cnt_ff);
      band_w         = (band_prod[2*CW-1:8] >= bdtw_pkg::WIN_W'(len_diff)) ?
                       bdtw_pkg::WIN_W'(band_prod[2*CW-1:8]) : bdtw_pkg::WIN_W'(len_diff);
      rmax           = (ref_rough_ff > q_rough_ff) ? ref_rough_ff : q_rough_ff;
      rmin           = (ref_rough_ff > q_rough_ff) ? q_rough_ff : ref_rough_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && req_type == bdtw_pkg::REQ_QUERY && req_last) state_in = ST_START;
         ST_START:  state_in = invalid_now ? ST_OUT : ST_FEED;
         ST_FEED:   if (feed_ff == ref_cnt_ff) state_in = ST_WAIT;
         ST_WAIT: begin
            if (links[bdtw_pkg::MAX_LEN].fin_valid) begin
               state_in = links[bdtw_pkg::MAX_LEN].fin_ok ? ST_CSTART : ST_OUT;
            end
         end
         ST_CSTART: state_in = ST_CORR;
         ST_CORR:   if (corr_done) state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         band_ff       <= bdtw_pkg::BAND_RESET;
         ref_cnt_ff    <= '0;
         q_cnt_ff      <= '0;
         ref_rough_ff  <= '0;
         q_rough_ff    <= '0;
         ref_closed_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_FEED) && (feed_ff != ref_cnt_ff);
         if (csr_we) band_ff <= csr_wdata;
         if (accept && req_type == bdtw_pkg::REQ_REFERENCE) begin
            ref_closed_ff <= req_last;
            if (ref_wr) begin
               ref_cnt_ff   <= ref_base_cnt + CW'(1);
               ref_rough_ff <= (ref_base_cnt != '0) ?
                               bdtw_pkg::rough_add(ref_base_rough, last_ref_ff, req_sample) :
                               ref_base_rough;
            end else begin
               ref_cnt_ff   <= ref_base_cnt;
               ref_rough_ff <= ref_base_rough;
            end
         end
         if (q_wr) begin
            q_cnt_ff   <= q_cnt_ff + CW'(1);
            q_rough_ff <= (q_cnt_ff != '0) ?
                          bdtw_pkg::rough_add(q_rough_ff, last_q_ff, req_sample) : q_rough_ff;
         end
         // The reference stays for further queries; the query starts over.
         if (state_ff == ST_OUT && rsp_ready) begin
            q_cnt_ff   <= '0;
            q_rough_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ref_wr) begin
         ref_mem[ref_base_cnt[bdtw_pkg::IDX_W-1:0]] <= req_sample;
         last_ref_ff <= req_sample;
      end
      if (q_wr) last_q_ff <= req_sample;
      if (state_ff == ST_FEED) begin
         rd_data_ff <= ref_mem[feed_ff[bdtw_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      rd_i_ff <= feed_ff + CW'(1);
      if (state_ff == ST_START) begin
         w_ff    <= band_w;
         feed_ff <= '0;
         dist_ff <= '0;
         sat_ff  <= 1'b0;
         inv_ff  <= invalid_now;
      end
      if (state_ff == ST_FEED && feed_ff != ref_cnt_ff) begin
         feed_ff <= feed_ff + CW'(1);
      end
      if (state_ff == ST_WAIT && links[bdtw_pkg::MAX_LEN].fin_valid) begin
         acc_ff     <= links[bdtw_pkg::MAX_LEN].fin_cost;
         acc_sat_ff <= (links[bdtw_pkg::MAX_LEN].fin_cost == bdtw_pkg::COST_MAX);
         if (!links[bdtw_pkg::MAX_LEN].fin_ok) begin
            dist_ff <= bdtw_pkg::DIST_MAX;
            sat_ff  <= 1'b1;
         end
      end
      if (state_ff == ST_CORR && corr_done) begin
         dist_ff <= corr_dist;
         sat_ff  <= corr_clip || acc_sat_ff;
      end
   end

   // Head of the chain: the column left of the first query sample, reachable only
   // at the corner that row 1 sees diagonally.
   always_comb begin
      links[0].tok_valid = rd_valid_ff;
      links[0].tok_i     = rd_i_ff;
      links[0].tok_r     = rd_data_ff;
      links[0].cost      = '0;
      links[0].ok        = 1'b0;
      links[0].prev      = '0;
      links[0].prev_ok   = (rd_i_ff == CW'(1));
      links[0].fin_valid = 1'b0;
      links[0].fin_cost  = '0;
      links[0].fin_ok    = 1'b0;
   end

   for (genvar k = 0; k < bdtw_pkg::MAX_LEN; k++) begin : g_cell
      bdtw_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .clr    (clr),
         .idx    (bdtw_pkg::IDX_W'(k)),
         .n      (ref_cnt_ff),
         .m      (q_cnt_ff),
         .w      (w_ff),
         .q_we   (q_wr),
         .q_addr (q_cnt_ff[bdtw_pkg::IDX_W-1:0]),
         .q_data (req_sample),
         .left   (links[k]),
         .right  (links[k+1])
      );
   end

   bdtw_corr u_corr (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_CSTART),
      .acc      (acc_ff),
      .rmax     (rmax),
      .rmin     (rmin),
      .done     (corr_done),
      .distance (corr_dist),
      .clipped  (corr_clip)
   );

endmodule
